>>> src/gbs_pkg.sv
// Package for the greedy box suppression core: box and result types, verdict
// codes, default sizes and the threshold value after reset.
// Depends on nothing; used by gbs_iou_unit and greedy_box_suppression_core.
package gbs_pkg;

  localparam int MAX_KEPT_DEF  = 64;
  localparam int MAX_BOXES_DEF = 4096;

  localparam int COORD_W = 16;
  localparam int EXT_W   = 15;
  localparam int AREA_W  = 30;
  localparam int THR_W   = 9;
  localparam int IDX_W   = 12;

  localparam logic [THR_W-1:0] IOU_THR_RESET = 9'd154;

  localparam logic [1:0] VERDICT_SUPP = 2'd0;
  localparam logic [1:0] VERDICT_KEPT = 2'd1;
  localparam logic [1:0] VERDICT_FULL = 2'd2;

  typedef struct packed {
    logic [EXT_W-1:0]          h;
    logic [EXT_W-1:0]          w;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x0;
  } gbs_box_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    gbs_box_t          box;
  } gbs_entry_t;

  // status of the overlap pipeline towards the sequencer
  typedef struct packed {
    logic busy;
    logic vld;
    logic hit;
  } gbs_iou_res_t;

endpackage

>>> src/gbs_iou_unit.sv
// Pipelined overlap test of the held candidate box against one stored box per
// cycle: intersection, union and the inter*256 > thr*union compare.
// Depends on gbs_pkg.
module gbs_iou_unit
  import gbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  gbs_box_t           cand,
  input  logic [AREA_W-1:0]  cand_area,
  input  logic [THR_W-1:0]   thr,
  input  logic               ent_vld,
  input  gbs_entry_t         ent,
  output gbs_iou_res_t       res
);

  // stage 1: overlap extents
  logic signed [COORD_W:0]   ar, ab, br, bb, r, btm;
  logic signed [COORD_W-1:0] l, t;
  logic signed [COORD_W+1:0] dxw, dyw;
  logic [EXT_W-1:0]          dx_r, dy_r;
  logic [AREA_W-1:0]         barea_r;
  logic                      s1_vld_r;

  // stage 2: intersection and area sum
  logic [AREA_W-1:0]         inter_r;
  logic [AREA_W:0]           asum_r;
  logic                      s2_vld_r;

  // stage 3: both sides of the compare
  logic [AREA_W:0]           uni;
  logic [AREA_W+THR_W:0]     lhs_r, rhs_r;
  logic                      s3_vld_r;

  logic                      hit_r, hit_vld_r;

  always_comb begin
    ar  = $signed({cand.x0[COORD_W-1], cand.x0}) + $signed({2'b00, cand.w});
    ab  = $signed({cand.y0[COORD_W-1], cand.y0}) + $signed({2'b00, cand.h});
    br  = $signed({ent.box.x0[COORD_W-1], ent.box.x0}) + $signed({2'b00, ent.box.w});
    bb  = $signed({ent.box.y0[COORD_W-1], ent.box.y0}) + $signed({2'b00, ent.box.h});
    l   = (cand.x0 > ent.box.x0) ? cand.x0 : ent.box.x0;
    t   = (cand.y0 > ent.box.y0) ? cand.y0 : ent.box.y0;
    r   = (ar < br) ? ar : br;
    btm = (ab < bb) ? ab : bb;
    dxw = $signed({r[COORD_W], r}) - $signed({{2{l[COORD_W-1]}}, l});
    dyw = $signed({btm[COORD_W], btm}) - $signed({{2{t[COORD_W-1]}}, t});
  end

  // union never goes negative: the intersection is at most the smaller area
  assign uni = asum_r - {1'b0, inter_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      hit_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= ent_vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      hit_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    // touching or disjoint boxes give an empty overlap
    if (dxw > 0 && dyw > 0) begin
      dx_r <= dxw[EXT_W-1:0];
      dy_r <= dyw[EXT_W-1:0];
    end else begin
      dx_r <= '0;
      dy_r <= '0;
    end
    barea_r <= ent.area;
    inter_r <= dx_r * dy_r;
    asum_r  <= {1'b0, cand_area} + {1'b0, barea_r};
    lhs_r   <= {2'b00, inter_r, 8'h00};
    rhs_r   <= thr * uni;
    hit_r   <= lhs_r > rhs_r;
  end

  assign res.busy = s1_vld_r | s2_vld_r | s3_vld_r | hit_vld_r;
  assign res.vld  = hit_vld_r;
  assign res.hit  = hit_r;

endmodule

>>> src/greedy_box_suppression_core.sv
// Greedy non-maximum suppression by overlap ratio: sequencer, kept-box memory,
// threshold register and output register. Depends on gbs_pkg, gbs_iou_unit.
//
// channel | dir | handshake         | payload
// --------+-----+-------------------+------------------------------------------
// in_     | in  | in_tvalid/tready  | tdata x0,y0,w,h; tuser first_of_set
// out_    | out | out_tvalid/tready | tdata verdict, box_index
// cfg_    | in  | cfg_valid/ready   | cfg_data iou_threshold
//
// With kept boxes in the set, the scan issues one registered read per kept box
// into the four overlap stages; the sequencer then folds in the last hit, sees
// the pipeline empty in S_DRAIN and loads the output register in S_DONE. The
// next box is taken only after that. An empty table skips the scan.
// rst_n is synchronous; it empties the kept table and the box counter and sets
// the threshold to 154/256. Stored boxes themselves are not cleared.
// A new box is taken while a finished result waits in the output register;
// that box stalls before its verdict until the output transaction completes.
module greedy_box_suppression_core
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT  = MAX_KEPT_DEF,
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // x0[15:0], y0[31:16], w[46:32], h[61:47], 0
  input  logic [0:0]       in_tuser,   // first_of_set
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // verdict[1:0], box_index[13:2], 0
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data    // iou_threshold
);

  localparam int KAW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KCW = $clog2(MAX_KEPT + 1);
  localparam int BCW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam logic [KCW-1:0] KEPT_LIMIT = KCW'(MAX_KEPT);
  localparam logic [BCW-1:0] BOX_LAST   = BCW'(MAX_BOXES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [THR_W-1:0]  thr_r;
  logic [KCW-1:0]    kept_cnt_r, kept_cnt_nxt;
  logic [KCW-1:0]    scan_r, scan_nxt;
  logic [BCW-1:0]    box_cnt_r, box_cnt_nxt;
  logic              supp_r, supp_nxt;
  gbs_box_t          cand_r;
  logic [AREA_W-1:0] cand_area_r;

  logic              out_vld_r, out_vld_nxt;
  logic [1:0]        verdict_r;
  logic [IDX_W-1:0]  idx_r;

  // kept table: one write and one registered read port
  gbs_entry_t        mem [MAX_KEPT];
  gbs_entry_t        rd_data_r;
  logic              rd_vld_r;
  logic              rd_en;
  logic              wr_en;
  logic [1:0]        verdict;

  gbs_box_t          in_box;
  logic              in_fire, out_fire, done_fire;
  logic [KCW-1:0]    cnt_eff;
  logic [BCW+IDX_W-1:0] box_cnt_wide;
  gbs_iou_res_t      iou_res;

  assign in_box    = in_tdata[61:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_vld_r & out_tready;
  assign done_fire = (state_r == S_DONE) & (~out_vld_r | out_tready);
  assign cfg_ready = 1'b1;
  assign cnt_eff   = in_tuser[0] ? '0 : kept_cnt_r;
  assign rd_en     = (state_r == S_SCAN);
  assign box_cnt_wide = {{IDX_W{1'b0}}, box_cnt_r};

  always_comb begin
    if (supp_r) begin
      verdict = VERDICT_SUPP;
    end else if (kept_cnt_r < KEPT_LIMIT) begin
      verdict = VERDICT_KEPT;
    end else begin
      verdict = VERDICT_FULL;
    end
  end

  assign wr_en = done_fire & (verdict == VERDICT_KEPT);

  always_comb begin
    state_nxt    = state_r;
    kept_cnt_nxt = kept_cnt_r;
    scan_nxt     = scan_r;
    box_cnt_nxt  = box_cnt_r;
    supp_nxt     = supp_r | (iou_res.vld & iou_res.hit);
    out_vld_nxt  = out_vld_r & ~out_fire;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kept_cnt_nxt = cnt_eff;
          if (in_tuser[0]) begin
            box_cnt_nxt = '0;
          end
          scan_nxt  = '0;
          supp_nxt  = 1'b0;
          state_nxt = (cnt_eff == '0) ? S_DRAIN : S_SCAN;
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r + 1'b1 == kept_cnt_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !iou_res.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          out_vld_nxt = 1'b1;
          if (wr_en) begin
            kept_cnt_nxt = kept_cnt_r + 1'b1;
          end
          box_cnt_nxt = (box_cnt_r == BOX_LAST) ? '0 : box_cnt_r + 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      thr_r      <= IOU_THR_RESET;
      kept_cnt_r <= '0;
      scan_r     <= '0;
      box_cnt_r  <= '0;
      supp_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      kept_cnt_r <= kept_cnt_nxt;
      scan_r     <= scan_nxt;
      box_cnt_r  <= box_cnt_nxt;
      supp_r     <= supp_nxt;
      out_vld_r  <= out_vld_nxt;
      rd_vld_r   <= rd_en;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cand_r      <= in_box;
      cand_area_r <= in_box.w * in_box.h;
    end
    if (done_fire) begin
      verdict_r <= verdict;
      idx_r     <= box_cnt_wide[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[kept_cnt_r[KAW-1:0]] <= '{area: cand_area_r, box: cand_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_r[KAW-1:0]];
    end
  end

  gbs_iou_unit u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .cand      (cand_r),
    .cand_area (cand_area_r),
    .thr       (thr_r),
    .ent_vld   (rd_vld_r),
    .ent       (rd_data_r),
    .res       (iou_res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, idx_r, verdict_r};

  // the table never holds more than its depth
  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_cnt_r <= KEPT_LIMIT)
    else $error("kept count beyond table depth");

  // a new box is only taken once the overlap pipeline is empty
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rd_vld_r && !iou_res.busy))
    else $error("overlap pipeline busy while idle");

  // a stored box bumps the kept count by one
  a_store_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (kept_cnt_r == $past(kept_cnt_r) + 1'b1))
    else $error("kept count not advanced on store");

  // the verdict register never holds the unused code
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (verdict_r == VERDICT_SUPP || verdict_r == VERDICT_KEPT ||
                   verdict_r == VERDICT_FULL))
    else $error("bad verdict code");

endmodule
